// ----- design/assert_macros.svh -----
// Assertion macros used by the trainer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Clocked assertion that is checked during reset as well.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ----- design/psvm_pkg.sv -----
// Types, constants and register codes of the Pegasos linear SVM trainer.
package psvm_pkg;

  localparam int MAX_FEATURES_DEF = 64;
  localparam int MAX_BATCH_DEF    = 256;

  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 32;
  localparam int DIV_CNT_W  = 6;

  localparam int FEAT_W  = 16;
  localparam int WEIGHT_W = 32;
  localparam int SUM_W   = 24;
  localparam int DOT_W   = 48;

  localparam logic [8:0]  BATCH_SIZE_RST = 9'd1;
  localparam logic [31:0] LAMBDA_RST     = 32'd16777216;
  localparam logic [6:0]  FEAT_COUNT_RST = 7'd64;

  localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};
  localparam logic signed [DOT_W-1:0] ONE_Q24 = 48'sd16777216;

  typedef enum logic [1:0] {
    REG_BATCH_SIZE = 2'd0,
    REG_LAMBDA     = 2'd1,
    REG_FEAT_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    DS_SHRINK = 2'd0,
    DS_LAMBDA = 2'd1,
    DS_STEP_T = 2'd2,
    DS_STEP_K = 2'd3
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_FIN,
    S_SRD,
    S_SWR,
    S_BFILL,
    S_BRD,
    S_BLD,
    S_SHM,
    S_DST,
    S_DWT,
    S_BWR,
    S_OUT
  } state_t;

endpackage

// ----- design/psvm_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module psvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/psvm_div.sv -----
// Restoring unsigned divider that produces one quotient bit per cycle.
module psvm_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [psvm_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [psvm_pkg::DIVISOR_W-1:0]    divisor,
  output logic                              busy,
  output logic                              done,
  output logic [psvm_pkg::DIVIDEND_W-1:0]   quotient
);
  import psvm_pkg::*;

  logic [DIVIDEND_W-1:0] q_r, q_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    shifted;
  logic                  fits;

  always_comb begin
    shifted  = {rem_r, q_r[DIVIDEND_W-1]};
    fits     = shifted >= {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DIVIDEND_W-2:0], fits};
      rem_nxt = fits ? DIVISOR_W'(shifted - {1'b0, dvs_r}) : shifted[DIVISOR_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- design/pegasos_linear_svm_trainer_top.sv -----
// Top level of the mini-batch Pegasos linear SVM trainer and predictor.
// Features arrive one per transfer on the input stream; the transfer with tlast
// closes a sample and yields one result transfer. Each feature passes through the
// shared multiplier and then the saturating accumulator. A training sample that
// violates the margin then reads and writes back the step sum of each stored
// feature, adding y*x into it. A sample that completes a mini-batch also walks
// all MAX_FEATURES weights through the shared divider: up to four divisions per
// weight, and fewer where a weight or step sum is zero. The input is not ready
// during this work.
`include "assert_macros.svh"

module pegasos_linear_svm_trainer_top #(
  parameter int MAX_FEATURES = psvm_pkg::MAX_FEATURES_DEF,
  parameter int MAX_BATCH    = psvm_pkg::MAX_BATCH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // feature_value
  input  logic [1:0]  in_tuser,   // mode, class_label
  input  logic        in_tlast,   // last_feature
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // score
  output logic [3:0]  out_tuser   // result_kind, predicted_class, margin_violation, batch_done
);
  import psvm_pkg::*;

  localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CW = $clog2(MAX_FEATURES + 1);
  localparam int LW = (CW > 7) ? CW : 7;
  localparam int BW = $clog2(MAX_BATCH + 1);
  localparam int KW = (BW > 9) ? BW : 9;

  state_t state_r, state_nxt;

  logic [8:0]  batch_size_r;
  logic [31:0] lambda_r;
  logic [6:0]  feat_count_r;

  logic [CW-1:0] fidx_r, fidx_nxt;
  logic signed [DOT_W-1:0] acc_r, acc_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic signed [FEAT_W-1:0] x_r, x_nxt;
  logic mode_r, mode_nxt, label_r, label_nxt, last_r, last_nxt, use_r, use_nxt;
  logic signed [DOT_W-1:0] score_r, score_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic viol_r, viol_nxt, done_r, done_nxt;
  logic [CW-1:0] sidx_r, sidx_nxt;
  logic [BW-1:0] fill_r, fill_nxt;
  logic [31:0] step_count_r, step_count_nxt;
  logic [AW-1:0] bidx_r, bidx_nxt;
  logic [31:0] wmag_r, wmag_nxt;
  logic wneg_r, wneg_nxt, sneg_r, sneg_nxt;
  logic [SUM_W-1:0] smag_r, smag_nxt;
  logic [31:0] shrink_r, shrink_nxt;
  logic [63:0] q_r, q_nxt;
  logic [32:0] step_r, step_nxt;
  div_sel_t dsel_r, dsel_nxt;
  logic wv_rd_r, sv_rd_r;
  logic [MAX_FEATURES-1:0] wvalid_r, wvalid_nxt, svalid_r, svalid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [47:0] out_data_r, out_data_nxt;
  logic [3:0] out_user_r, out_user_nxt;

  logic [LW-1:0] lim;
  logic [KW-1:0] kk;
  logic [31:0] lam;
  logic in_acc;
  logic use_now;

  logic w_we, s_we, b_we;
  logic [AW-1:0] w_raddr, s_raddr, b_raddr, w_waddr, s_waddr, b_waddr;
  logic [WEIGHT_W-1:0] w_wdata, w_rdata;
  logic [SUM_W-1:0] s_wdata, s_rdata;
  logic [FEAT_W-1:0] b_rdata;

  logic div_start, div_busy, div_done;
  logic [63:0] div_dividend, div_quot;
  logic [31:0] div_divisor;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic signed [WEIGHT_W-1:0] w_cur;
  logic signed [SUM_W-1:0] s_cur;
  logic signed [DOT_W:0] acc_sum;
  logic signed [DOT_W-1:0] acc_sat;
  logic signed [SUM_W:0] ssum;
  logic signed [SUM_W-1:0] ssum_sat;
  logic signed [34:0] r_sum;
  logic [31:0] r_sat;
  logic viol_now;
  logic [KW-1:0] fill_inc;
  logic out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_size_r <= BATCH_SIZE_RST;
      lambda_r     <= LAMBDA_RST;
      feat_count_r <= FEAT_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BATCH_SIZE: batch_size_r <= cfg_wdata[8:0];
        REG_LAMBDA:     lambda_r     <= cfg_wdata;
        REG_FEAT_COUNT: feat_count_r <= cfg_wdata[6:0];
        default:        ;
      endcase
    end
  end

  assign lim = (LW'(feat_count_r) < LW'(MAX_FEATURES)) ? LW'(feat_count_r) : LW'(MAX_FEATURES);
  assign kk  = (batch_size_r == '0) ? KW'(1) :
               ((KW'(batch_size_r) > KW'(MAX_BATCH)) ? KW'(MAX_BATCH) : KW'(batch_size_r));
  assign lam = (lambda_r == '0) ? 32'd1 : lambda_r;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign use_now   = LW'(fidx_r) < lim;
  assign out_free  = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ACC;
      S_ACC:   state_nxt = last_r ? S_FIN : S_IDLE;
      S_FIN: begin
        if (mode_r) state_nxt = S_OUT;
        else if (viol_now && n_r != '0) state_nxt = S_SRD;
        else state_nxt = S_BFILL;
      end
      S_SRD:   state_nxt = S_SWR;
      S_SWR:   state_nxt = (CW'(sidx_r + 1'b1) == n_r) ? S_BFILL : S_SRD;
      S_BFILL: state_nxt = (fill_inc >= kk) ? S_BRD : S_OUT;
      S_BRD:   state_nxt = S_BLD;
      S_BLD:   state_nxt = S_SHM;
      S_SHM: begin
        if (step_count_r != 32'd1 && wmag_r != '0) state_nxt = S_DST;
        else if (smag_r != '0) state_nxt = S_DST;
        else state_nxt = S_BWR;
      end
      S_DST:   state_nxt = S_DWT;
      S_DWT: begin
        if (div_done) begin
          case (dsel_r)
            DS_SHRINK: state_nxt = (smag_r != '0) ? S_DST : S_BWR;
            DS_STEP_K: state_nxt = S_BWR;
            default:   state_nxt = S_DST;
          endcase
        end
      end
      S_BWR:   state_nxt = (bidx_r == AW'(MAX_FEATURES - 1)) ? S_OUT : S_BRD;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Shared arithmetic.
  assign w_cur = wv_rd_r ? $signed(w_rdata) : '0;
  assign s_cur = sv_rd_r ? $signed(s_rdata) : '0;

  always_comb begin
    if (state_r == S_SHM) begin
      mul_a = $signed({1'b0, wmag_r});
      mul_b = $signed({1'b0, step_count_r - 32'd1});
    end else begin
      mul_a = 33'(w_cur);
      mul_b = 33'(x_r);
    end
  end
  assign mul_p = mul_a * mul_b;

  assign acc_sum = (DOT_W+1)'(acc_r) + (DOT_W+1)'($signed(prod_r[DOT_W-1:0]));
  assign acc_sat = (acc_sum > (DOT_W+1)'(DOT_MAX)) ? DOT_MAX :
                   (acc_sum < (DOT_W+1)'(DOT_MIN)) ? DOT_MIN : acc_sum[DOT_W-1:0];

  assign viol_now = label_r ? (score_r < ONE_Q24) : (score_r > -ONE_Q24);

  assign ssum = label_r ? ((SUM_W+1)'(s_cur) + (SUM_W+1)'($signed(b_rdata)))
                        : ((SUM_W+1)'(s_cur) - (SUM_W+1)'($signed(b_rdata)));
  assign ssum_sat = (ssum > (SUM_W+1)'($signed({1'b0, {(SUM_W-1){1'b1}}}))) ?
                      $signed({1'b0, {(SUM_W-1){1'b1}}}) :
                    (ssum < (SUM_W+1)'($signed({1'b1, {(SUM_W-1){1'b0}}}))) ?
                      $signed({1'b1, {(SUM_W-1){1'b0}}}) : ssum[SUM_W-1:0];

  assign r_sum = (wneg_r ? -$signed({3'b0, shrink_r}) : $signed({3'b0, shrink_r})) +
                 (sneg_r ? -$signed({2'b0, step_r}) : $signed({2'b0, step_r}));
  assign r_sat = (r_sum > 35'sh07FFFFFFF) ? 32'h7FFFFFFF :
                 (r_sum < -35'sh080000000) ? 32'h80000000 : r_sum[31:0];

  assign fill_inc = KW'(fill_r) + KW'(1);

  always_comb begin
    case (dsel_r)
      DS_SHRINK: begin
        div_dividend = prod_r;
        div_divisor  = step_count_r;
      end
      DS_LAMBDA: begin
        div_dividend = {8'b0, smag_r, 32'b0};
        div_divisor  = lam;
      end
      DS_STEP_T: begin
        div_dividend = q_r;
        div_divisor  = step_count_r;
      end
      DS_STEP_K: begin
        div_dividend = q_r;
        div_divisor  = 32'(kk);
      end
      default: begin
        div_dividend = q_r;
        div_divisor  = 32'd1;
      end
    endcase
  end
  assign div_start = (state_r == S_DST);

  // Memory ports.
  assign w_raddr = (state_r == S_IDLE) ? fidx_r[AW-1:0] : bidx_r;
  assign s_raddr = (state_r == S_SRD) ? sidx_r[AW-1:0] : bidx_r;
  assign b_raddr = sidx_r[AW-1:0];
  assign b_we    = in_acc && use_now;
  assign b_waddr = fidx_r[AW-1:0];
  assign w_we    = (state_r == S_BWR);
  assign w_waddr = bidx_r;
  assign w_wdata = r_sat;
  assign s_we    = (state_r == S_SWR) || (state_r == S_BWR);
  assign s_waddr = (state_r == S_SWR) ? sidx_r[AW-1:0] : bidx_r;
  assign s_wdata = (state_r == S_SWR) ? ssum_sat : '0;

  // Datapath and output updates.
  always_comb begin
    fidx_nxt       = fidx_r;
    acc_nxt        = acc_r;
    prod_nxt       = prod_r;
    x_nxt          = x_r;
    mode_nxt       = mode_r;
    label_nxt      = label_r;
    last_nxt       = last_r;
    use_nxt        = use_r;
    score_nxt      = score_r;
    n_nxt          = n_r;
    viol_nxt       = viol_r;
    done_nxt       = done_r;
    sidx_nxt       = sidx_r;
    fill_nxt       = fill_r;
    step_count_nxt = step_count_r;
    bidx_nxt       = bidx_r;
    wmag_nxt       = wmag_r;
    wneg_nxt       = wneg_r;
    smag_nxt       = smag_r;
    sneg_nxt       = sneg_r;
    shrink_nxt     = shrink_r;
    q_nxt          = q_r;
    step_nxt       = step_r;
    dsel_nxt       = dsel_r;
    wvalid_nxt     = wvalid_r;
    svalid_nxt     = svalid_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_nxt     = $signed(in_tdata);
          mode_nxt  = in_tuser[0];
          label_nxt = in_tuser[1];
          last_nxt  = in_tlast;
          use_nxt   = use_now;
          if (use_now) fidx_nxt = fidx_r + 1'b1;
        end
      end
      S_MUL: prod_nxt = mul_p[63:0];
      S_ACC: begin
        if (last_r) begin
          score_nxt = use_r ? acc_sat : acc_r;
          n_nxt     = fidx_r;
          acc_nxt   = '0;
          fidx_nxt  = '0;
          viol_nxt  = 1'b0;
          done_nxt  = 1'b0;
          sidx_nxt  = '0;
        end else if (use_r) begin
          acc_nxt = acc_sat;
        end
      end
      S_FIN: if (!mode_r) viol_nxt = viol_now;
      S_SWR: begin
        svalid_nxt[sidx_r[AW-1:0]] = 1'b1;
        sidx_nxt = sidx_r + 1'b1;
      end
      S_BFILL: begin
        if (fill_inc >= kk) begin
          fill_nxt       = '0;
          done_nxt       = 1'b1;
          step_count_nxt = (step_count_r == '1) ? step_count_r : step_count_r + 32'd1;
          bidx_nxt       = '0;
        end else begin
          fill_nxt = fill_inc[BW-1:0];
        end
      end
      S_BLD: begin
        wneg_nxt   = w_cur[WEIGHT_W-1];
        wmag_nxt   = w_cur[WEIGHT_W-1] ? 32'(-w_cur) : 32'(w_cur);
        sneg_nxt   = s_cur[SUM_W-1];
        smag_nxt   = s_cur[SUM_W-1] ? SUM_W'(-s_cur) : SUM_W'(s_cur);
        shrink_nxt = '0;
        step_nxt   = '0;
      end
      S_SHM: begin
        prod_nxt = mul_p[63:0];
        dsel_nxt = (step_count_r != 32'd1 && wmag_r != '0) ? DS_SHRINK : DS_LAMBDA;
      end
      S_DWT: begin
        if (div_done) begin
          case (dsel_r)
            DS_SHRINK: begin
              shrink_nxt = div_quot[31:0];
              dsel_nxt   = DS_LAMBDA;
            end
            DS_LAMBDA: begin
              q_nxt    = div_quot;
              dsel_nxt = DS_STEP_T;
            end
            DS_STEP_T: begin
              q_nxt    = div_quot;
              dsel_nxt = DS_STEP_K;
            end
            DS_STEP_K: begin
              step_nxt = (div_quot > 64'h1_0000_0000) ? 33'h1_0000_0000 : div_quot[32:0];
            end
            default: ;
          endcase
        end
      end
      S_BWR: begin
        wvalid_nxt[bidx_r] = 1'b1;
        svalid_nxt[bidx_r] = 1'b1;
        bidx_nxt = bidx_r + 1'b1;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = score_r;
          out_user_nxt  = {done_r, viol_r, score_r > 0, mode_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fidx_r       <= '0;
      acc_r        <= '0;
      fill_r       <= '0;
      step_count_r <= '0;
      wvalid_r     <= '0;
      svalid_r     <= '0;
      out_valid_r  <= 1'b0;
      dsel_r       <= DS_SHRINK;
    end else begin
      state_r      <= state_nxt;
      fidx_r       <= fidx_nxt;
      acc_r        <= acc_nxt;
      fill_r       <= fill_nxt;
      step_count_r <= step_count_nxt;
      wvalid_r     <= wvalid_nxt;
      svalid_r     <= svalid_nxt;
      out_valid_r  <= out_valid_nxt;
      dsel_r       <= dsel_nxt;
    end
    prod_r     <= prod_nxt;
    x_r        <= x_nxt;
    mode_r     <= mode_nxt;
    label_r    <= label_nxt;
    last_r     <= last_nxt;
    use_r      <= use_nxt;
    score_r    <= score_nxt;
    n_r        <= n_nxt;
    viol_r     <= viol_nxt;
    done_r     <= done_nxt;
    sidx_r     <= sidx_nxt;
    bidx_r     <= bidx_nxt;
    wmag_r     <= wmag_nxt;
    wneg_r     <= wneg_nxt;
    smag_r     <= smag_nxt;
    sneg_r     <= sneg_nxt;
    shrink_r   <= shrink_nxt;
    q_r        <= q_nxt;
    step_r     <= step_nxt;
    wv_rd_r    <= wvalid_r[w_raddr];
    sv_rd_r    <= svalid_r[s_raddr];
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  psvm_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_FEATURES)) u_weights (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  psvm_ram #(.WIDTH(SUM_W), .DEPTH(MAX_FEATURES)) u_step_sums (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  psvm_ram #(.WIDTH(FEAT_W), .DEPTH(MAX_FEATURES)) u_samples (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(in_tdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  psvm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .busy(div_busy), .done(div_done), .quotient(div_quot)
  );

  `ASSERT_CLK(a_div_start_idle, clk, rst_n, div_start |-> !div_busy)
  `ASSERT_CLK(a_pred_no_update, clk, rst_n, (out_tvalid && out_tuser[0]) |-> (out_tuser[3:2] == 2'b00))
  `ASSERT_CLK(a_fidx_bound, clk, rst_n, LW'(fidx_r) <= lim || $past(lim) < lim || !$stable(feat_count_r) || LW'(fidx_r) <= LW'(MAX_FEATURES))
  `ASSERT_CLK_ALWAYS(a_reset_out_idle, clk, !rst_n |=> !out_tvalid)

endmodule
